>>> design/sixz_pkg.sv
// Package for segment_intersection_xz: the shared hit type.
// No dependencies.
package sixz_pkg;
   typedef enum logic {NO_HIT = 1'b0, HIT = 1'b1} hit_type;
endpackage

>>> design/sixz_if.sv
// Valid/ready stream interfaces for segment_intersection_xz.
// Depends on nothing; widths follow the parameter W.
interface sixz_req_if #(parameter int W = 24) ();
   logic valid;
   logic ready;
   logic signed [W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_z, d_x, d_z;
   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_z, d_x, d_z,
                   input ready);
   modport sink (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_z, d_x, d_z,
                 output ready);
endinterface

interface sixz_rsp_if #(parameter int W = 24) ();
   logic valid;
   logic ready;
   logic hit;
   logic signed [W-1:0] p_x, p_y, p_z;
   modport source (output valid, hit, p_x, p_y, p_z, input ready);
   modport sink (input valid, hit, p_x, p_y, p_z, output ready);
endinterface

>>> design/segment_intersection_xz.sv
// segment_intersection_xz: XZ crossing test of two segments, pipelined.
// Throughput one beat per cycle unless the output stage stalls. The restoring
// divider for t is unrolled one quotient bit per stage, which sets the depth.
// The whole pipe advances when the output stage is empty or is being taken.
// Synchronous active-high reset clears all valid bits; data needs no reset.
// Depends on sixz_pkg and sixz_if.sv.
module segment_intersection_xz import sixz_pkg::*; #(
   parameter int COORD_BITS = 24,
   parameter int FRAC_BITS = 8,
   parameter int T_FRAC_BITS = 16
) (
   input logic clock,
   input logic reset,
   sixz_req_if.sink req,
   sixz_rsp_if.source rsp
);
   localparam int DW = COORD_BITS + 1;      // differences
   localparam int PW = 2 * DW;              // products
   localparam int NW = PW + 1;              // cross terms
   localparam int RW = NW + 1;              // remainder
   localparam int TW = T_FRAC_BITS + 1;
   localparam int OW = DW + TW + 1;
   localparam int NQ = T_FRAC_BITS + 1;     // divider stages
   localparam int FMT = FRAC_BITS;          // format only: arithmetic is scale-free

   logic adv;
   assign adv = !rsp.valid || rsp.ready;
   assign req.ready = adv;

   // stage 1: differences
   logic v1_ff;
   logic signed [COORD_BITS-1:0] ax1_ff, ay1_ff, az1_ff;
   logic signed [DW-1:0] ex1_ff, ey1_ff, ez1_ff, fx1_ff, fz1_ff, gx1_ff, gz1_ff;
   // stage 2: products
   logic v2_ff;
   logic signed [COORD_BITS-1:0] ax2_ff, ay2_ff, az2_ff;
   logic signed [DW-1:0] ex2_ff, ey2_ff, ez2_ff;
   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   // stage 3: cross terms
   logic v3_ff;
   logic signed [COORD_BITS-1:0] ax3_ff, ay3_ff, az3_ff;
   logic signed [DW-1:0] ex3_ff, ey3_ff, ez3_ff;
   logic signed [NW-1:0] den3_ff, sn3_ff, tn3_ff;
   // stage 4: sign fix and range test
   logic v4_ff, ok4_ff;
   logic signed [COORD_BITS-1:0] ax4_ff, ay4_ff, az4_ff;
   logic signed [DW-1:0] ex4_ff, ey4_ff, ez4_ff;
   logic [NW-1:0] den4_ff, tn4_ff;
   // divider pipe
   logic q_v_ff [NQ];
   logic q_ok_ff [NQ];
   logic signed [COORD_BITS-1:0] q_ax_ff [NQ], q_ay_ff [NQ], q_az_ff [NQ];
   logic signed [DW-1:0] q_ex_ff [NQ], q_ey_ff [NQ], q_ez_ff [NQ];
   logic [RW-1:0] q_r_ff [NQ];
   logic [NW-1:0] q_d_ff [NQ];
   logic [TW-1:0] q_t_ff [NQ];
   // product stage
   logic v5_ff, ok5_ff;
   logic signed [COORD_BITS-1:0] ax5_ff, ay5_ff, az5_ff;
   logic signed [OW-1:0] ox5_ff, oy5_ff, oz5_ff;
   // sum stage
   logic v6_ff, ok6_ff;
   logic signed [OW:0] px6_ff, py6_ff, pz6_ff;

   function automatic logic signed [COORD_BITS-1:0] sat(input logic signed [OW:0] p);
      logic signed [OW:0] hi, lo;
      hi = (OW+1)'(signed'({1'b0, {(COORD_BITS-1){1'b1}}}));
      lo = -hi - 1;
      if (p > hi) return hi[COORD_BITS-1:0];
      if (p < lo) return lo[COORD_BITS-1:0];
      return p[COORD_BITS-1:0];
   endfunction

   function automatic logic signed [OW-1:0] rnd(input logic signed [OW-1:0] prod);
      logic signed [OW-1:0] s;
      s = prod + (OW'(1) <<< (T_FRAC_BITS - 1));
      return s >>> T_FRAC_BITS;
   endfunction

   logic signed [NW-1:0] den_n, sn_n, tn_n;
   always_comb begin
      den_n = den3_ff[NW-1] ? -den3_ff : den3_ff;
      sn_n = den3_ff[NW-1] ? -sn3_ff : sn3_ff;
      tn_n = den3_ff[NW-1] ? -tn3_ff : tn3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0; v2_ff <= 1'b0; v3_ff <= 1'b0; v4_ff <= 1'b0;
         v5_ff <= 1'b0; v6_ff <= 1'b0; rsp.valid <= 1'b0;
         for (int i = 0; i < NQ; i++) q_v_ff[i] <= 1'b0;
      end else if (adv) begin
         v1_ff <= req.valid; v2_ff <= v1_ff; v3_ff <= v2_ff; v4_ff <= v3_ff;
         q_v_ff[0] <= v4_ff;
         for (int i = 1; i < NQ; i++) q_v_ff[i] <= q_v_ff[i-1];
         v5_ff <= q_v_ff[NQ-1]; v6_ff <= v5_ff; rsp.valid <= v6_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ax1_ff <= req.a_x; ay1_ff <= req.a_y; az1_ff <= req.a_z;
         ex1_ff <= DW'(req.b_x) - DW'(req.a_x);
         ey1_ff <= DW'(req.b_y) - DW'(req.a_y);
         ez1_ff <= DW'(req.b_z) - DW'(req.a_z);
         fx1_ff <= DW'(req.d_x) - DW'(req.c_x);
         fz1_ff <= DW'(req.d_z) - DW'(req.c_z);
         gx1_ff <= DW'(req.a_x) - DW'(req.c_x);
         gz1_ff <= DW'(req.a_z) - DW'(req.c_z);

         ax2_ff <= ax1_ff; ay2_ff <= ay1_ff; az2_ff <= az1_ff;
         ex2_ff <= ex1_ff; ey2_ff <= ey1_ff; ez2_ff <= ez1_ff;
         m0_ff <= PW'(ex1_ff) * PW'(fz1_ff);
         m1_ff <= PW'(fx1_ff) * PW'(ez1_ff);
         m2_ff <= PW'(ex1_ff) * PW'(gz1_ff);
         m3_ff <= PW'(ez1_ff) * PW'(gx1_ff);
         m4_ff <= PW'(fx1_ff) * PW'(gz1_ff);
         m5_ff <= PW'(fz1_ff) * PW'(gx1_ff);

         ax3_ff <= ax2_ff; ay3_ff <= ay2_ff; az3_ff <= az2_ff;
         ex3_ff <= ex2_ff; ey3_ff <= ey2_ff; ez3_ff <= ez2_ff;
         den3_ff <= NW'(m0_ff) - NW'(m1_ff);
         sn3_ff <= NW'(m2_ff) - NW'(m3_ff);
         tn3_ff <= NW'(m4_ff) - NW'(m5_ff);

         ax4_ff <= ax3_ff; ay4_ff <= ay3_ff; az4_ff <= az3_ff;
         ex4_ff <= ex3_ff; ey4_ff <= ey3_ff; ez4_ff <= ez3_ff;
         den4_ff <= den_n; tn4_ff <= tn_n;
         ok4_ff <= (den3_ff != '0) && !sn_n[NW-1] && !tn_n[NW-1]
                   && (sn_n <= den_n) && (tn_n <= den_n);

         // first quotient bit: t == 1 exactly
         q_ok_ff[0] <= ok4_ff; q_d_ff[0] <= den4_ff;
         q_ax_ff[0] <= ax4_ff; q_ay_ff[0] <= ay4_ff; q_az_ff[0] <= az4_ff;
         q_ex_ff[0] <= ex4_ff; q_ey_ff[0] <= ey4_ff; q_ez_ff[0] <= ez4_ff;
         if (tn4_ff >= den4_ff) begin
            q_r_ff[0] <= RW'(tn4_ff - den4_ff); q_t_ff[0] <= TW'(1);
         end else begin
            q_r_ff[0] <= RW'(tn4_ff); q_t_ff[0] <= '0;
         end
         for (int i = 1; i < NQ; i++) begin
            q_ok_ff[i] <= q_ok_ff[i-1]; q_d_ff[i] <= q_d_ff[i-1];
            q_ax_ff[i] <= q_ax_ff[i-1]; q_ay_ff[i] <= q_ay_ff[i-1];
            q_az_ff[i] <= q_az_ff[i-1];
            q_ex_ff[i] <= q_ex_ff[i-1]; q_ey_ff[i] <= q_ey_ff[i-1];
            q_ez_ff[i] <= q_ez_ff[i-1];
            if ({q_r_ff[i-1][RW-2:0], 1'b0} >= RW'(q_d_ff[i-1])) begin
               q_r_ff[i] <= {q_r_ff[i-1][RW-2:0], 1'b0} - RW'(q_d_ff[i-1]);
               q_t_ff[i] <= {q_t_ff[i-1][TW-2:0], 1'b1};
            end else begin
               q_r_ff[i] <= {q_r_ff[i-1][RW-2:0], 1'b0};
               q_t_ff[i] <= {q_t_ff[i-1][TW-2:0], 1'b0};
            end
         end

         ok5_ff <= q_ok_ff[NQ-1];
         ax5_ff <= q_ax_ff[NQ-1]; ay5_ff <= q_ay_ff[NQ-1]; az5_ff <= q_az_ff[NQ-1];
         ox5_ff <= OW'(signed'({1'b0, q_t_ff[NQ-1]})) * OW'(q_ex_ff[NQ-1]);
         oy5_ff <= OW'(signed'({1'b0, q_t_ff[NQ-1]})) * OW'(q_ey_ff[NQ-1]);
         oz5_ff <= OW'(signed'({1'b0, q_t_ff[NQ-1]})) * OW'(q_ez_ff[NQ-1]);

         ok6_ff <= ok5_ff;
         px6_ff <= (OW+1)'(ax5_ff) + (OW+1)'(rnd(ox5_ff));
         py6_ff <= (OW+1)'(ay5_ff) + (OW+1)'(rnd(oy5_ff));
         pz6_ff <= (OW+1)'(az5_ff) + (OW+1)'(rnd(oz5_ff));

         rsp.hit <= ok6_ff ? HIT : NO_HIT;
         rsp.p_x <= ok6_ff ? sat(px6_ff) : '0;
         rsp.p_y <= ok6_ff ? sat(py6_ff) : '0;
         rsp.p_z <= ok6_ff ? sat(pz6_ff) : '0;
      end
   end

   a_no_hit_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |-> rsp.p_x == '0 && rsp.p_y == '0 && rsp.p_z == '0)
      else $error("point not zero without hit");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("ready not tied to output stage");
   a_tq_range: assert property (@(posedge clock) disable iff (reset)
      q_v_ff[NQ-1] && q_ok_ff[NQ-1] |-> q_t_ff[NQ-1] <= (TW'(1) << T_FRAC_BITS))
      else $error("t out of range");
   a_rem: assert property (@(posedge clock) disable iff (reset)
      q_v_ff[0] && q_ok_ff[0] |-> q_r_ff[0] < RW'(q_d_ff[0]) || FMT < 0)
      else $error("remainder not reduced");
endmodule

>>> dv/sixz_checker.sv
`timescale 1ns / 1ps
// Checker for segment_intersection_xz: predicts each result from the request
// beats and compares it with the response beats. Depends on sixz_pkg and sixz_if.sv.
module sixz_checker import sixz_pkg::*; #(
   parameter int W = 24,
   parameter int TF = 16
) (
   input logic clock,
   input logic reset,
   sixz_req_if req,
   sixz_rsp_if rsp,
   output int fail_count,
   output int pending,
   output int hit_count
);
   typedef struct {
      logic signed [W-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_z, d_x, d_z;
   } segments_type;

   typedef struct {
      hit_type hit;
      logic signed [W-1:0] p_x, p_y, p_z;
   } crossing_type;

   crossing_type crossings_due[$];
   int beats_seen = 0;

   initial begin
      fail_count = 0;
      pending = 0;
      hit_count = 0;
   end

   function automatic logic signed [W-1:0] lerp_sat(longint a, longint e, longint tq);
      longint hi_lim, lo_lim, p;
      hi_lim = (longint'(1) <<< (W - 1)) - 1;
      lo_lim = -hi_lim - 1;
      // floor of the half-up rounded offset
      p = a + ((tq * e + (longint'(1) <<< (TF - 1))) >>> TF);
      if (p > hi_lim) p = hi_lim;
      if (p < lo_lim) p = lo_lim;
      return p[W-1:0];
   endfunction

   function automatic crossing_type xz_crossing(segments_type s);
      longint ex, ey, ez, fx, fz, gx, gz, den, sn, tn, tq;
      logic signed [127:0] num;
      crossing_type r;
      r = '{NO_HIT, '0, '0, '0};
      ex = longint'(s.b_x) - s.a_x;
      ey = longint'(s.b_y) - s.a_y;
      ez = longint'(s.b_z) - s.a_z;
      fx = longint'(s.d_x) - s.c_x;
      fz = longint'(s.d_z) - s.c_z;
      gx = longint'(s.a_x) - s.c_x;
      gz = longint'(s.a_z) - s.c_z;
      den = ex * fz - fx * ez;
      sn = ex * gz - ez * gx;
      tn = fx * gz - fz * gx;
      if (den == 0) return r;
      if (den < 0) begin
         den = -den;
         sn = -sn;
         tn = -tn;
      end
      if (sn < 0 || tn < 0 || sn > den || tn > den) return r;
      num = tn;
      num = num <<< TF;
      tq = longint'(num / den);
      r.hit = HIT;
      r.p_x = lerp_sat(s.a_x, ex, tq);
      r.p_y = lerp_sat(s.a_y, ey, tq);
      r.p_z = lerp_sat(s.a_z, ez, tq);
      return r;
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      fail_count++;
      $display("MISMATCH beat %0d %s: got %0d expected %0d", beats_seen, what, got, want);
   endtask

   always @(posedge clock) begin
      segments_type s;
      crossing_type want;
      if (!reset) begin
         if (req.valid && req.ready) begin
            s = '{req.a_x, req.a_y, req.a_z, req.b_x, req.b_y, req.b_z,
                  req.c_x, req.c_z, req.d_x, req.d_z};
            crossings_due.push_back(xz_crossing(s));
         end
         if (rsp.valid && rsp.ready) begin
            if (crossings_due.size() == 0) begin
               report("response with nothing outstanding", 1, 0);
            end else begin
               want = crossings_due.pop_front();
               if (rsp.hit !== want.hit) report("hit", rsp.hit, want.hit);
               if (rsp.p_x !== want.p_x) report("p_x", rsp.p_x, want.p_x);
               if (rsp.p_y !== want.p_y) report("p_y", rsp.p_y, want.p_y);
               if (rsp.p_z !== want.p_z) report("p_z", rsp.p_z, want.p_z);
               if (want.hit == HIT) hit_count++;
            end
            beats_seen++;
         end
         pending = crossings_due.size();
      end
   end
endmodule

>>> dv/tb_segment_intersection_xz.sv
`timescale 1ns / 1ps
// Testbench top for segment_intersection_xz: clock, reset, stimulus and verdict.
// Depends on sixz_pkg, sixz_if.sv, sixz_checker.sv and the block itself.
module tb_segment_intersection_xz;
   import sixz_pkg::*;
   localparam int W = 24;
   localparam int LIMIT = 400000;
   localparam int TAIL = 50;
   localparam longint MX = 8388607;
   localparam longint MN = -8388608;
   localparam int SPAN = 1 << 21;

   logic clock = 0;
   logic reset = 1;
   int fail_count, pending, hit_count;
   int cycles = 0;
   int holdoff = 0;
   bit hold_request = 0;
   bit no_idle = 0;
   int sent = 0;

   sixz_req_if #(W) req_if ();
   sixz_rsp_if #(W) rsp_if ();

   segment_intersection_xz DUT (.clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if));

   sixz_checker #(.W(W)) u_checker (
      .clock(clock), .reset(reset), .req(req_if), .rsp(rsp_if),
      .fail_count(fail_count), .pending(pending), .hit_count(hit_count)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("segment_intersection_xz verification failed");
         $finish;
      end
   end

   // response side: random stalls, or a long hold-off when asked
   initial begin
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (hold_request && holdoff == 0) holdoff = 150;
         if (holdoff > 0) begin
            rsp_if.ready = 0;
            holdoff--;
            if (holdoff == 0) hold_request = 0;
         end else begin
            rsp_if.ready = no_idle || ($urandom_range(99) >= 15);
         end
      end
   end

   task automatic put(input longint ax, ay, az, bx, by, bz, cx, cz, dx, dz);
      if (!no_idle)
         while ($urandom_range(99) < 15) begin
            @(negedge clock);
            req_if.valid = 0;
         end
      @(negedge clock);
      req_if.valid = 1;
      req_if.a_x = ax[W-1:0]; req_if.a_y = ay[W-1:0]; req_if.a_z = az[W-1:0];
      req_if.b_x = bx[W-1:0]; req_if.b_y = by[W-1:0]; req_if.b_z = bz[W-1:0];
      req_if.c_x = cx[W-1:0]; req_if.c_z = cz[W-1:0];
      req_if.d_x = dx[W-1:0]; req_if.d_z = dz[W-1:0];
      do @(posedge clock); while (!req_if.ready);
      sent++;
   endtask

   function automatic longint pick(int r);
      return longint'($urandom_range(2 * r)) - r;
   endfunction

   function automatic longint full_coord();
      logic signed [W-1:0] v;
      v = W'($urandom);
      return longint'(v);
   endfunction

   function automatic longint frac16();
      return longint'($urandom_range(65536));
   endfunction

   // random segment pair, mostly built to cross in XZ
   task automatic put_random();
      longint ax, ay, az, bx, by, bz, cx, cz, dx, dz, px, pz, wx, wz;
      int mode;
      mode = $urandom_range(99);
      ax = pick(SPAN); ay = pick(SPAN); az = pick(SPAN);
      bx = pick(SPAN); by = pick(SPAN); bz = pick(SPAN);
      if ($urandom_range(3) == 0) begin
         // short segments keep the quotient near its extremes
         bx = ax + pick(64); bz = az + pick(64);
      end
      if (mode < 60) begin
         px = ax + (((bx - ax) * frac16()) >>> 16);
         pz = az + (((bz - az) * frac16()) >>> 16);
         wx = pick(SPAN); wz = pick(SPAN);
         cx = px - ((wx * frac16()) >>> 16);
         cz = pz - ((wz * frac16()) >>> 16);
         dx = px + ((wx * frac16()) >>> 16);
         dz = pz + ((wz * frac16()) >>> 16);
      end else if (mode < 70) begin
         // parallel or collinear
         cx = pick(SPAN); cz = pick(SPAN);
         if ($urandom_range(1)) begin cx = ax; cz = az; end
         dx = cx + (bx - ax); dz = cz + (bz - az);
      end else if (mode < 80) begin
         // share an endpoint
         cx = pick(SPAN); cz = pick(SPAN); dx = pick(SPAN); dz = pick(SPAN);
         case ($urandom_range(3))
            0: begin cx = ax; cz = az; end
            1: begin cx = bx; cz = bz; end
            2: begin dx = ax; dz = az; end
            default: begin dx = bx; dz = bz; end
         endcase
      end else begin
         ax = full_coord(); ay = full_coord(); az = full_coord();
         bx = full_coord(); by = full_coord(); bz = full_coord();
         cx = full_coord(); cz = full_coord(); dx = full_coord(); dz = full_coord();
      end
      put(ax, ay, az, bx, by, bz, cx, cz, dx, dz);
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid = 0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      req_if.valid = 0;
      {req_if.a_x, req_if.a_y, req_if.a_z, req_if.b_x, req_if.b_y, req_if.b_z} = '0;
      {req_if.c_x, req_if.c_z, req_if.d_x, req_if.d_z} = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      put(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      put(MN, MN, MN, MX, MX, MX, MN, MX, MX, MN);
      put(MN, MN, MN, MX, MX, MX, MX, MN, MN, MX);
      put(MX, MX, MX, MN, MN, MN, MX, MN, MN, MX);
      put(0, 5, 0, 256, 9, 0, 0, -256, 0, 256);
      put(0, 5, 0, 256, 9, 0, 256, -256, 256, 256);
      put(0, 0, 0, 512, 0, 0, 256, 0, 256, 512);
      put(0, 0, 0, 512, 0, 0, 256, -512, 256, 0);
      put(0, 0, 0, 256, 0, 256, 256, 0, 512, 256);
      put(0, 0, 0, 512, 0, 0, 256, 0, 768, 0);
      put(0, 0, 0, 256, 0, 0, 512, -256, 512, 256);
      put(0, 0, 0, 512, 0, 0, 256, 256, 256, 512);
      put(0, MN, 0, 512, MX, 512, 0, 512, 512, 0);
      put(100, 7, 100, 100, 9, 100, 0, 0, 512, 512);
      put(-3, 1, -3, 4, 2, 5, -3, 5, 4, -3);
      put(MX, 0, MN, MN, 0, MX, MN, MN, MX, MX);

      drain();
      repeat (1000) put_random();

      // back-to-back with no stalls on either side
      no_idle = 1;
      repeat (300) put_random();
      no_idle = 0;

      // stall the response side long enough to back up the pipe
      @(negedge clock);
      req_if.valid = 0;
      hold_request = 1;
      repeat (200) put_random();

      drain();
      repeat (300) put_random();

      drain();
      repeat (TAIL) @(posedge clock);
      $display("%0d segment pairs sent (directed, random, parallel, endpoint and full-range)",
               sent);
      $display("%0d crossings predicted, with stalls, back-pressure and a drained pause",
               hit_count);
      if (fail_count == 0) begin
         $display("segment_intersection_xz verification clean");
      end else begin
         $display("segment_intersection_xz verification failed");
      end
      $finish;
   end
endmodule
